// ===== rtl/core/u2l_pkg.sv =====
// ----------------------------------------------------------------------------
// u2l_pkg: shared types, constants and the byte classifier
// Symbol and result records shared by the request front end, the decode
// engine and the top level.
// ----------------------------------------------------------------------------
package u2l_pkg;

   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_U      = 8'h75;
   localparam logic [7:0] CHAR_NUL    = 8'h00;

   localparam logic [7:0] MASK_TOP    = 8'h80;
   localparam logic [7:0] MASK_LEAD2  = 8'hE0;
   localparam logic [7:0] CODE_LEAD2  = 8'hC0;
   localparam logic [7:0] MASK_LEAD3  = 8'hF0;
   localparam logic [7:0] CODE_LEAD3  = 8'hE0;
   localparam logic [7:0] MASK_LEAD4  = 8'hF8;
   localparam logic [7:0] CODE_LEAD4  = 8'hF0;

   localparam int FRONT_DEPTH = 4;
   localparam int RSP_DEPTH   = 4;

   localparam int              CSR_ADDR_BITS     = 3;
   localparam logic            REG_IDX_MAX_CHARS = 1'b0;
   localparam logic [15:0]     MAX_CHARS_RESET   = 16'd4096;

   typedef enum logic [2:0] {
      KIND_END    = 3'd0,
      KIND_PLAIN  = 3'd1,
      KIND_BSLASH = 3'd2,
      KIND_LEAD2  = 3'd3,
      KIND_LEAD3  = 3'd4,
      KIND_LEAD4  = 3'd5,
      KIND_STRAY  = 3'd6
   } kind_type;

   typedef struct packed {
      logic [7:0] byte_val;
      kind_type   kind;
      logic       is_u;
      logic       hex_ok;
      logic [3:0] hex_val;
   } sym_type;

   typedef struct packed {
      logic [7:0]  out_char;
      logic        is_last;
      logic [15:0] char_count;
   } rsp_type;

   function automatic sym_type classify(input logic [7:0] b, input logic eot);
      sym_type    s;
      logic [7:0] d;
      d          = 8'h00;
      s.byte_val = b;
      s.is_u     = (b == CHAR_U);
      s.hex_ok   = 1'b0;
      if (b >= 8'h30 && b <= 8'h39) begin
         s.hex_ok = 1'b1;
         d        = b - 8'h30;
      end else if (b >= 8'h61 && b <= 8'h66) begin
         s.hex_ok = 1'b1;
         d        = b - 8'h57;
      end else if (b >= 8'h41 && b <= 8'h46) begin
         s.hex_ok = 1'b1;
         d        = b - 8'h37;
      end
      s.hex_val = d[3:0];
      priority if (eot || b == CHAR_NUL) begin
         s.kind = KIND_END;
      end else if ((b & MASK_TOP) == 8'h00) begin
         s.kind = (b == CHAR_BSLASH) ? KIND_BSLASH : KIND_PLAIN;
      end else if ((b & MASK_LEAD2) == CODE_LEAD2) begin
         s.kind = KIND_LEAD2;
      end else if ((b & MASK_LEAD3) == CODE_LEAD3) begin
         s.kind = KIND_LEAD3;
      end else if ((b & MASK_LEAD4) == CODE_LEAD4) begin
         s.kind = KIND_LEAD4;
      end else begin
         s.kind = KIND_STRAY;
      end
      return s;
   endfunction

endpackage

// ===== rtl/core/u2l_fifo.sv =====
// ----------------------------------------------------------------------------
// u2l_fifo: small register queue
// First-in first-out queue in flip-flops with show-ahead read data.
// ----------------------------------------------------------------------------
module u2l_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                wr_ok, rd_ok;

   assign full    = (cnt_ff == CNT_BITS'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign wr_ok   = wr_en && !full;
   assign rd_ok   = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (wr_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({wr_ok, rd_ok})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== rtl/core/u2l_front.sv =====
// ----------------------------------------------------------------------------
// u2l_front: request front end
// Classifies each accepted request byte and queues it for the decode engine.
// ----------------------------------------------------------------------------
module u2l_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [7:0]        in_byte,
   input  logic              end_of_text,
   input  logic              head_pop,
   output logic              head_valid,
   output u2l_pkg::sym_type  head
);
   import u2l_pkg::*;

   sym_type          sym_new;
   logic             q_empty;
   logic [$bits(sym_type)-1:0] q_rd;

   assign sym_new = classify(in_byte, end_of_text);

   u2l_fifo #(
      .WIDTH ($bits(sym_type)),
      .DEPTH (FRONT_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (sym_new),
      .full    (full),
      .rd_en   (head_pop),
      .rd_data (q_rd),
      .empty   (q_empty)
   );

   assign head       = sym_type'(q_rd);
   assign head_valid = !q_empty;

endmodule

// ===== rtl/core/u2l_back.sv =====
// ----------------------------------------------------------------------------
// u2l_back: decode engine
// Runs the escape / UTF-8 decoder on one symbol, giving at most one result, per
// cycle unless the result queue is full; replays partial escape bytes at text end.
// ----------------------------------------------------------------------------
module u2l_back #(
   parameter int COUNT_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [15:0]       max_chars,
   input  logic              sym_valid,
   input  u2l_pkg::sym_type  sym,
   output logic              sym_pop,
   input  logic              res_full,
   output logic              res_push,
   output u2l_pkg::rsp_type  res
);
   import u2l_pkg::*;

   localparam int CMP_BITS = (COUNT_BITS > 16) ? COUNT_BITS : 16;

   typedef enum logic [5:0] {
      MODE_IDLE    = 6'b000001,
      MODE_LEAD2   = 6'b000010,
      MODE_SKIP    = 6'b000100,
      MODE_BSLASH  = 6'b001000,
      MODE_DIGITS  = 6'b010000,
      MODE_FLUSH_U = 6'b100000
   } mode_type;

   mode_type              mode_ff, mode_in;
   logic [4:0]            lead_ff, lead_in;
   logic [1:0]            skip_ff, skip_in;
   logic [7:0]            raw_ff [3];
   logic [7:0]            raw_in [3];
   logic [1:0]            seen_ff, seen_in;
   logic [15:0]           accum_ff, accum_in;
   logic                  open_ff, open_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [7:0]            rep_buf_ff [3];
   logic [7:0]            rep_buf_in [3];
   logic [1:0]            rep_left_ff, rep_left_in;
   logic [1:0]            rep_idx_ff, rep_idx_in;

   sym_type               cur;
   logic                  from_replay;
   logic                  step;
   logic                  consume;
   logic                  do_emit;
   logic [7:0]            emit_ch;
   logic                  term;
   logic                  room;
   logic [COUNT_BITS-1:0] count_inc;
   logic [CMP_BITS-1:0]   count_ext, count_inc_ext;
   logic [15:0]           accum_new;
   logic [10:0]           code_point;

   assign from_replay = (rep_left_ff != 2'd0);
   assign cur         = from_replay ? classify(rep_buf_ff[rep_idx_ff], 1'b0) : sym;
   assign step        = (from_replay || sym_valid) && !res_full;

   assign count_inc     = (count_ff == '1) ? count_ff : count_ff + 1'b1;
   assign count_ext     = CMP_BITS'(count_ff);
   assign count_inc_ext = CMP_BITS'(count_inc);
   assign room          = (count_ext < CMP_BITS'(max_chars));

   assign accum_new  = (open_ff && cur.hex_ok) ? {accum_ff[11:0], cur.hex_val} : accum_ff;
   assign code_point = {lead_ff, cur.byte_val[5:0]};

   always_comb begin
      mode_in     = mode_ff;
      lead_in     = lead_ff;
      skip_in     = skip_ff;
      raw_in      = raw_ff;
      seen_in     = seen_ff;
      accum_in    = accum_ff;
      open_in     = open_ff;
      rep_buf_in  = rep_buf_ff;
      rep_left_in = rep_left_ff;
      rep_idx_in  = rep_idx_ff;
      consume     = 1'b0;
      do_emit     = 1'b0;
      emit_ch     = cur.byte_val;
      term        = 1'b0;

      if (step) begin
         unique case (mode_ff)
            MODE_IDLE: begin
               if (cur.kind == KIND_END) begin
                  term    = 1'b1;
                  consume = 1'b1;
               end else begin
                  consume = 1'b1;
                  unique case (cur.kind)
                     KIND_PLAIN:  do_emit = 1'b1;
                     KIND_BSLASH: mode_in = MODE_BSLASH;
                     KIND_LEAD2: begin
                        lead_in = cur.byte_val[4:0];
                        mode_in = MODE_LEAD2;
                     end
                     KIND_LEAD3: begin
                        skip_in = 2'd2;
                        mode_in = MODE_SKIP;
                     end
                     KIND_LEAD4: begin
                        skip_in = 2'd3;
                        mode_in = MODE_SKIP;
                     end
                     default: ;
                  endcase
               end
            end
            MODE_LEAD2: begin
               consume = 1'b1;
               if (cur.kind == KIND_END) begin
                  term = 1'b1;
               end else begin
                  mode_in = MODE_IDLE;
                  lead_in = 5'd0;
                  // code points of 256 and up are dropped uncounted
                  do_emit = (code_point[10:8] == 3'd0);
                  emit_ch = code_point[7:0];
               end
            end
            MODE_SKIP: begin
               consume = 1'b1;
               if (cur.kind == KIND_END) begin
                  term = 1'b1;
               end else begin
                  skip_in = skip_ff - 1'b1;
                  if (skip_ff == 2'd1) begin
                     mode_in = MODE_IDLE;
                  end
               end
            end
            MODE_BSLASH: begin
               if (cur.kind != KIND_END && cur.is_u) begin
                  consume  = 1'b1;
                  mode_in  = MODE_DIGITS;
                  seen_in  = 2'd0;
                  accum_in = 16'd0;
                  open_in  = 1'b1;
               end else begin
                  // literal backslash; the symbol is left in place and decoded again
                  do_emit = 1'b1;
                  emit_ch = CHAR_BSLASH;
                  mode_in = MODE_IDLE;
               end
            end
            MODE_DIGITS: begin
               if (cur.kind == KIND_END) begin
                  do_emit = 1'b1;
                  emit_ch = CHAR_BSLASH;
                  mode_in = MODE_FLUSH_U;
               end else begin
                  consume  = 1'b1;
                  accum_in = accum_new;
                  if (!(open_ff && cur.hex_ok)) begin
                     open_in = 1'b0;
                  end
                  if (seen_ff == 2'd3) begin
                     mode_in = MODE_IDLE;
                     seen_in = 2'd0;
                     do_emit = (accum_new < 16'd128);
                     emit_ch = accum_new[7:0];
                  end else begin
                     raw_in[seen_ff] = cur.byte_val;
                     seen_in         = seen_ff + 1'b1;
                  end
               end
            end
            MODE_FLUSH_U: begin
               // emit the 'u', then replay the collected escape bytes
               do_emit     = 1'b1;
               emit_ch     = CHAR_U;
               mode_in     = MODE_IDLE;
               rep_buf_in  = raw_ff;
               rep_left_in = seen_ff;
               rep_idx_in  = 2'd0;
               seen_in     = 2'd0;
            end
            default: mode_in = MODE_IDLE;
         endcase

         if (consume && from_replay) begin
            rep_idx_in  = rep_idx_ff + 1'b1;
            rep_left_in = rep_left_ff - 1'b1;
         end

         if (term) begin
            mode_in  = MODE_IDLE;
            lead_in  = 5'd0;
            skip_in  = 2'd0;
            seen_in  = 2'd0;
            accum_in = 16'd0;
            open_in  = 1'b1;
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (step && term) begin
         count_in = '0;
      end else if (step && do_emit) begin
         count_in = count_inc;
      end
   end

   assign sym_pop  = step && consume && !from_replay;
   assign res_push = step && (term || (do_emit && room));

   always_comb begin
      res.out_char   = term ? CHAR_NUL : emit_ch;
      res.is_last    = term;
      res.char_count = term ? count_ext[15:0] : count_inc_ext[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         lead_ff     <= 5'd0;
         skip_ff     <= 2'd0;
         seen_ff     <= 2'd0;
         accum_ff    <= 16'd0;
         open_ff     <= 1'b1;
         count_ff    <= '0;
         rep_left_ff <= 2'd0;
         rep_idx_ff  <= 2'd0;
      end else begin
         mode_ff     <= mode_in;
         lead_ff     <= lead_in;
         skip_ff     <= skip_in;
         seen_ff     <= seen_in;
         accum_ff    <= accum_in;
         open_ff     <= open_in;
         count_ff    <= count_in;
         rep_left_ff <= rep_left_in;
         rep_idx_ff  <= rep_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff     <= raw_in;
      rep_buf_ff <= rep_buf_in;
   end

   // the 'u' flush step only runs with the end-of-text request still at the head
   a_flush_at_end: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_FLUSH_U |-> rep_left_ff == 2'd0 && sym_valid && sym.kind == KIND_END)
      else $error("u flush without pending end of text");

   a_replay_bounds: assert property (@(posedge clock) disable iff (reset)
      rep_left_ff != 2'd0 |-> ({1'b0, rep_idx_ff} + {1'b0, rep_left_ff}) <= 3'd3)
      else $error("replay index out of range");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      res_push |-> !res_full)
      else $error("result pushed into full queue");

   a_term_clears: assert property (@(posedge clock) disable iff (reset)
      step && term |=> count_ff == '0 && mode_ff == MODE_IDLE && open_ff && rep_left_ff == 2'd0)
      else $error("state not cleared after terminator");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      sym_pop |-> sym_valid && !from_replay)
      else $error("front queue popped while empty or replaying");

endmodule

// ===== rtl/core/utf8_to_latin1_filter.sv =====
// ----------------------------------------------------------------------------
// utf8_to_latin1_filter: byte stream to 8-bit text filter
// Front end queue, decode engine, result queue and the register port.
// ----------------------------------------------------------------------------
// A request carries one text byte, or marks end of text (end_of_text high or
// a zero byte). ASCII passes through, a two-byte UTF-8 sequence gives its code
// point when below 256, longer sequences and stray bytes vanish, and a
// backslash-u escape with four following bytes gives its hex value when below
// 128. The end-of-text request flushes a partial escape as literal bytes and
// yields a terminator result with the total count. Requests go one per cycle
// into a four-deep queue while it is not full; the decode engine retires one
// symbol and produces at most one result per cycle while the result queue
// is not full. The byte after a backslash not followed by 'u' is decoded
// again. At end of text a pending backslash is emitted first; a partial
// backslash-u escape yields its backslash, its 'u' and a replay of the
// collected bytes (again if they leave another escape open). Results wait
// in a four-deep queue. max_chars lies at byte address 0 of the register port.
// ----------------------------------------------------------------------------
module utf8_to_latin1_filter #(
   parameter int COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_text,
   // result channel
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_is_last,
   output logic [15:0] rsp_char_count,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [u2l_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import u2l_pkg::*;

   logic [15:0] max_chars_ff, max_chars_in;
   logic        reg_idx;
   logic        head_valid, head_pop;
   sym_type     head;
   logic        res_full, res_push;
   rsp_type     res, rsp_head;
   logic [$bits(rsp_type)-1:0] rsp_rd;

   assign pready  = 1'b1;
   assign reg_idx = paddr[2];

   always_comb begin
      max_chars_in = max_chars_ff;
      if (psel && penable && pwrite && pready && reg_idx == REG_IDX_MAX_CHARS) begin
         max_chars_in = pwdata[15:0];
      end
   end

   assign prdata = (reg_idx == REG_IDX_MAX_CHARS) ? {16'd0, max_chars_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_chars_ff <= MAX_CHARS_RESET;
      end else begin
         max_chars_ff <= max_chars_in;
      end
   end

   u2l_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .in_byte     (req_in_byte),
      .end_of_text (req_end_of_text),
      .head_pop    (head_pop),
      .head_valid  (head_valid),
      .head        (head)
   );

   u2l_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .max_chars (max_chars_ff),
      .sym_valid (head_valid),
      .sym       (head),
      .sym_pop   (head_pop),
      .res_full  (res_full),
      .res_push  (res_push),
      .res       (res)
   );

   u2l_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (res_push),
      .wr_data (res),
      .full    (res_full),
      .rd_en   (pop),
      .rd_data (rsp_rd),
      .empty   (empty)
   );

   assign rsp_head       = rsp_type'(rsp_rd);
   assign rsp_out_char   = rsp_head.out_char;
   assign rsp_is_last    = rsp_head.is_last;
   assign rsp_char_count = rsp_head.char_count;

endmodule
